@@ src/assert_macros.svh @@
// Assertion helpers, included by cubic_bezier_subdivide.sv.
// Each macro checks a property on the rising edge of the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that is ignored while the given reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property that is checked during reset as well.
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)

`endif

`endif

@@ src/bzs_pkg.sv @@
`timescale 1ns / 1ps

package bzs_pkg;

  // Coordinate and parameter formats.
  parameter int COORD_WIDTH = 24;
  parameter int T_FRAC_BITS = 16;
  parameter int T_WIDTH = T_FRAC_BITS + 1;
  parameter int IDX_WIDTH = 3;

  // Curve shape: cubic, so four control points and seven emitted points.
  parameter int DEGREE = 3;
  parameter int FEED_LEN = DEGREE + 1;
  parameter int NUM_POINTS = 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [T_WIDTH-1:0] t_t;
  typedef logic [IDX_WIDTH-1:0] idx_t;

  // The value 1.0 of the split parameter.
  parameter t_t T_ONE = t_t'(1) << T_FRAC_BITS;

  // Point numbers of the first and the last emitted point.
  parameter idx_t IDX_FIRST = idx_t'(0);
  parameter idx_t IDX_LAST = idx_t'(NUM_POINTS - 1);

  // Input word: four control points and the split parameter.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_a_x;
    coord_t ctrl_a_y;
    coord_t ctrl_b_x;
    coord_t ctrl_b_y;
    coord_t finish_x;
    coord_t finish_y;
    t_t     split_t;
  } item_t;

  // Output word: one point of the subdivided curve.
  typedef struct packed {
    idx_t   point_index;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } result_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Word handed from one interpolation cell to the next.
  typedef struct packed {
    logic   valid;
    logic   first;
    logic   last;
    t_t     t;
    point_t pt;
  } cell_word_t;

  // a + (b - a) * t / 2^T_FRAC_BITS, rounded toward minus infinity.
  // The result always lies between a and b, so it fits a coordinate.
  function automatic coord_t lerp_floor(coord_t a, coord_t b, t_t t);
    logic signed [COORD_WIDTH:0]               diff;
    logic signed [COORD_WIDTH+T_WIDTH+1:0]     prod;
    logic signed [COORD_WIDTH+T_WIDTH+1:0]     scaled;
    logic signed [COORD_WIDTH+1:0]             sum;
    diff = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
    prod = diff * $signed({1'b0, t});
    scaled = prod >>> T_FRAC_BITS;
    sum = {a[COORD_WIDTH-1], a[COORD_WIDTH-1], a} + scaled[COORD_WIDTH+1:0];
    return sum[COORD_WIDTH-1:0];
  endfunction

endpackage

@@ src/bzs_cell.sv @@
`timescale 1ns / 1ps

// One level of the de Casteljau triangle. The cell keeps the previous point
// of the incoming row and, for every later point, emits the interpolation
// between the two. A row of n points in gives a row of n - 1 points out.
module bzs_cell (
  input  logic                clk,
  input  logic                rst,
  input  bzs_pkg::cell_word_t in_word,
  output bzs_pkg::cell_word_t out_word
);

  bzs_pkg::point_t prev;
  logic            prev_first;
  logic            out_valid;
  logic            out_first;
  logic            out_last;
  bzs_pkg::t_t     out_t;
  bzs_pkg::point_t out_pt;

  // Control: an output word follows every input word but the first of a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_first <= 1'b0;
    end else begin
      out_valid <= in_word.valid && !in_word.first;
      if (in_word.valid) begin
        prev_first <= in_word.first;
      end
    end
  end

  // Data: hold the previous point and interpolate on both axes.
  always_ff @(posedge clk) begin
    if (in_word.valid) begin
      prev <= in_word.pt;
    end
    out_first <= prev_first;
    out_last <= in_word.last;
    out_t <= in_word.t;
    out_pt.x <= bzs_pkg::lerp_floor(prev.x, in_word.pt.x, in_word.t);
    out_pt.y <= bzs_pkg::lerp_floor(prev.y, in_word.pt.y, in_word.t);
  end

  assign out_word.valid = out_valid;
  assign out_word.first = out_first;
  assign out_word.last = out_last;
  assign out_word.t = out_t;
  assign out_word.pt = out_pt;

endmodule

@@ src/cubic_bezier_subdivide.sv @@
`timescale 1ns / 1ps

// Cubic Bezier subdivision by de Casteljau's scheme.
// Input: a word (four control points and split_t) is taken at a rising edge
// with start high and busy low. split_t above 1.0 is treated as 1.0.
// Output: seven words per input word, on consecutive cycles, each
// marked by strobe for one cycle: P0, L1, L2, the split point, R1, R2, P3.
// last_point is high on the seventh. The receiver cannot hold results off.
// Timing: the word passes the feeder, the three cells and the output
// register before strobe rises with the first point and the rest follow.
// Pacing: busy rises after each accept and holds the next word off, as
// set by the single result port that carries seven points. A new word
// is taken while the previous one is still in the cell chain and while
// its points are still being sent.
// The control points enter a row of three interpolation cells one point a
// cycle; the edges of each level are captured and sent in order.
// Reset (synchronous) empties the chain and drops any points not yet sent.
module cubic_bezier_subdivide (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bzs_pkg::item_t   item,
  output logic             strobe,
  output bzs_pkg::result_t result
);

`include "assert_macros.svh"

  logic [2:0]          busy_cnt;
  logic                accept;
  bzs_pkg::t_t         t_sat;

  bzs_pkg::point_t     feed_pts [0:bzs_pkg::FEED_LEN-1];
  logic [2:0]          feed_cnt;
  bzs_pkg::t_t         feed_t;

  bzs_pkg::cell_word_t w [0:bzs_pkg::DEGREE];

  bzs_pkg::point_t     left_pt [0:bzs_pkg::DEGREE-1];
  bzs_pkg::point_t     right_pt [0:bzs_pkg::DEGREE-1];

  bzs_pkg::point_t     bank [0:bzs_pkg::NUM_POINTS-2];
  logic [2:0]          rem;
  bzs_pkg::point_t     res_pt;
  bzs_pkg::idx_t       res_idx;

  // Input handshake: busy holds the next word off after each accept.
  assign busy = (busy_cnt != 3'd0);
  assign accept = start && !busy;
  assign t_sat = (item.split_t > bzs_pkg::T_ONE) ? bzs_pkg::T_ONE : item.split_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= 3'd0;
    end else if (accept) begin
      busy_cnt <= 3'(bzs_pkg::NUM_POINTS - 1);
    end else if (busy) begin
      busy_cnt <= busy_cnt - 3'd1;
    end
  end

  // Feeder: sends the four control points into the chain, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_cnt <= 3'd0;
    end else if (accept) begin
      feed_cnt <= 3'(bzs_pkg::FEED_LEN);
    end else if (feed_cnt != 3'd0) begin
      feed_cnt <= feed_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      feed_pts[0] <= '{x: item.start_x, y: item.start_y};
      feed_pts[1] <= '{x: item.ctrl_a_x, y: item.ctrl_a_y};
      feed_pts[2] <= '{x: item.ctrl_b_x, y: item.ctrl_b_y};
      feed_pts[3] <= '{x: item.finish_x, y: item.finish_y};
      feed_t <= t_sat;
    end else begin
      for (int i = 0; i < bzs_pkg::FEED_LEN - 1; i++) begin
        feed_pts[i] <= feed_pts[i+1];
      end
    end
  end

  assign w[0].valid = (feed_cnt != 3'd0);
  assign w[0].first = (feed_cnt == 3'(bzs_pkg::FEED_LEN));
  assign w[0].last = (feed_cnt == 3'd1);
  assign w[0].t = feed_t;
  assign w[0].pt = feed_pts[0];

  // Chain of interpolation cells, one per level of the triangle.
  for (genvar g = 0; g < bzs_pkg::DEGREE; g++) begin : g_level
    bzs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_word  (w[g]),
      .out_word (w[g+1])
    );
  end

  // Capture the first and last point of every level but the apex.
  always_ff @(posedge clk) begin
    for (int k = 0; k < bzs_pkg::DEGREE; k++) begin
      if (w[k].valid && w[k].first) begin
        left_pt[k] <= w[k].pt;
      end
      if (w[k].valid && w[k].last) begin
        right_pt[k] <= w[k].pt;
      end
    end
  end

  // Output control: the apex completes a curve and starts its seven points.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      rem <= 3'd0;
    end else if (w[bzs_pkg::DEGREE].valid) begin
      strobe <= 1'b1;
      rem <= 3'(bzs_pkg::NUM_POINTS - 1);
    end else if (rem != 3'd0) begin
      strobe <= 1'b1;
      rem <= rem - 3'd1;
    end else begin
      strobe <= 1'b0;
    end
  end

  // Output data: load the points in curve order, then shift them out.
  always_ff @(posedge clk) begin
    if (w[bzs_pkg::DEGREE].valid) begin
      res_pt <= left_pt[0];
      res_idx <= bzs_pkg::IDX_FIRST;
      bank[0] <= left_pt[1];
      bank[1] <= left_pt[2];
      bank[2] <= w[bzs_pkg::DEGREE].pt;
      bank[3] <= right_pt[2];
      bank[4] <= right_pt[1];
      bank[5] <= right_pt[0];
    end else begin
      res_pt <= bank[0];
      res_idx <= res_idx + bzs_pkg::idx_t'(1);
      for (int i = 0; i < bzs_pkg::NUM_POINTS - 2; i++) begin
        bank[i] <= bank[i+1];
      end
    end
  end

  assign result.point_index = res_idx;
  assign result.point_x = res_pt.x;
  assign result.point_y = res_pt.y;
  assign result.last_point = (res_idx == bzs_pkg::IDX_LAST);

  // A new curve must never arrive while the previous one is still being sent.
  `ASSERT_CLK(a_no_overlap, clk, rst, w[bzs_pkg::DEGREE].valid |-> rem == 3'd0)
  // The apex level yields exactly one point, both first and last of its row.
  `ASSERT_CLK(a_apex_single, clk, rst, w[bzs_pkg::DEGREE].valid |-> (w[bzs_pkg::DEGREE].first && w[bzs_pkg::DEGREE].last))
  // After the last point comes either silence or the first point of a curve.
  `ASSERT_CLK(a_after_last, clk, rst, (strobe && result.last_point) |=> (!strobe || result.point_index == bzs_pkg::IDX_FIRST))
  // An accepted word blocks the input on the following cycle.
  `ASSERT_CLK(a_accept_busy, clk, rst, accept |=> busy)
  // Reset leaves the block idle.
  `ASSERT_CLK_NORST(a_reset_idle, clk, rst |=> (!strobe && !busy))

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam bzs_pkg::coord_t C_MAX = {1'b0, {(bzs_pkg::COORD_WIDTH-1){1'b1}}};
  localparam bzs_pkg::coord_t C_MIN = {1'b1, {(bzs_pkg::COORD_WIDTH-1){1'b0}}};
  localparam bzs_pkg::t_t T_TOP = '1;
  localparam int RANDOM_WORDS = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT = 2000;

  // Predicts the seven points of each accepted curve and checks them in order.
  class split_checker;
    bzs_pkg::result_t due_points[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // (1-t)*a + t*b on one axis, rounded toward minus infinity.
    function bzs_pkg::coord_t lerp_down(bzs_pkg::coord_t a, bzs_pkg::coord_t b, longint t);
      longint d;
      longint p;
      d = longint'(b) - longint'(a);
      p = d * t;
      return bzs_pkg::coord_t'(longint'(a) + (p >>> bzs_pkg::T_FRAC_BITS));
    endfunction

    // Builds the de Casteljau triangle for both axes and queues its edges.
    function void note_curve(bzs_pkg::item_t w);
      bzs_pkg::coord_t tx[4][4];
      bzs_pkg::coord_t ty[4][4];
      longint t;
      int lvl;
      int j;
      bzs_pkg::result_t r;
      // A split parameter above one is clamped to exactly one.
      t = (w.split_t > bzs_pkg::T_ONE) ? longint'(bzs_pkg::T_ONE) : longint'(w.split_t);
      tx[0][0] = w.start_x;  ty[0][0] = w.start_y;
      tx[0][1] = w.ctrl_a_x; ty[0][1] = w.ctrl_a_y;
      tx[0][2] = w.ctrl_b_x; ty[0][2] = w.ctrl_b_y;
      tx[0][3] = w.finish_x; ty[0][3] = w.finish_y;
      for (lvl = 1; lvl <= bzs_pkg::DEGREE; lvl++) begin
        for (j = 0; j <= bzs_pkg::DEGREE - lvl; j++) begin
          tx[lvl][j] = lerp_down(tx[lvl-1][j], tx[lvl-1][j+1], t);
          ty[lvl][j] = lerp_down(ty[lvl-1][j], ty[lvl-1][j+1], t);
        end
      end
      // Left edge downwards, then right edge back up.
      for (int k = 0; k < bzs_pkg::NUM_POINTS; k++) begin
        lvl = (k <= bzs_pkg::DEGREE) ? k : bzs_pkg::NUM_POINTS - 1 - k;
        j = (k <= bzs_pkg::DEGREE) ? 0 : k - bzs_pkg::DEGREE;
        r.point_index = bzs_pkg::idx_t'(k);
        r.point_x = tx[lvl][j];
        r.point_y = ty[lvl][j];
        r.last_point = (bzs_pkg::idx_t'(k) == bzs_pkg::IDX_LAST);
        due_points.push_back(r);
      end
    endfunction

    function void check_point(bzs_pkg::result_t got);
      bzs_pkg::result_t want;
      if (due_points.size() == 0) begin
        $error("point word with none expected: index %0d x %0d y %0d",
               got.point_index, got.point_x, got.point_y);
        errors++;
        return;
      end
      want = due_points.pop_front();
      if (got.point_index !== want.point_index) begin
        $error("point_index expected %0d actual %0d", want.point_index, got.point_index);
        errors++;
      end
      if (got.point_x !== want.point_x) begin
        $error("point_x expected %0d actual %0d", want.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y expected %0d actual %0d", want.point_y, got.point_y);
        errors++;
      end
      if (got.last_point !== want.last_point) begin
        $error("last_point expected %0d actual %0d", want.last_point, got.last_point);
        errors++;
      end
    endfunction

    function int pending();
      return due_points.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  bzs_pkg::item_t item;
  logic strobe;
  bzs_pkg::result_t result;
  int stall_cycles = 0;
  split_checker points = new();

  cubic_bezier_subdivide dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  always #5 clk = ~clk;

  // Accepted words and strobed points, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) points.note_curve(item);
      if (strobe) points.check_point(result);
    end
  end

  // Watchdog: too long without any word moving in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("cubic_bezier_subdivide verification failed");
      $finish;
    end
  end

  // A small coordinate given as an integer.
  function automatic bzs_pkg::coord_t cv(int v);
    return bzs_pkg::coord_t'(v);
  endfunction

  // Coordinates: full range in 3/8 of draws, else extremes or small values.
  function automatic bzs_pkg::coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return bzs_pkg::coord_t'($signed($urandom_range(0, 64)) - 32);
      3: return C_MAX - bzs_pkg::coord_t'($urandom_range(0, 255));
      4: return C_MIN + bzs_pkg::coord_t'($urandom_range(0, 255));
      default: return bzs_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Split parameter: mostly within [0, 1], sometimes at or beyond the ends.
  function automatic bzs_pkg::t_t rand_split();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bzs_pkg::T_ONE;
      2: return bzs_pkg::t_t'($urandom_range(bzs_pkg::T_ONE + 1, T_TOP));
      3: return bzs_pkg::t_t'($urandom_range(0, 15));
      4: return bzs_pkg::T_ONE - bzs_pkg::t_t'($urandom_range(1, 15));
      default: return bzs_pkg::t_t'($urandom_range(0, bzs_pkg::T_ONE));
    endcase
  endfunction

  function automatic bzs_pkg::item_t rand_curve();
    bzs_pkg::item_t w;
    w.start_x = rand_coord();
    w.start_y = rand_coord();
    w.ctrl_a_x = rand_coord();
    w.ctrl_a_y = rand_coord();
    w.ctrl_b_x = rand_coord();
    w.ctrl_b_y = rand_coord();
    w.finish_x = rand_coord();
    w.finish_y = rand_coord();
    w.split_t = rand_split();
    return w;
  endfunction

  function automatic bzs_pkg::item_t curve(
    bzs_pkg::coord_t sx, bzs_pkg::coord_t sy, bzs_pkg::coord_t ax, bzs_pkg::coord_t ay,
    bzs_pkg::coord_t bx, bzs_pkg::coord_t by, bzs_pkg::coord_t fx, bzs_pkg::coord_t fy,
    bzs_pkg::t_t t);
    bzs_pkg::item_t w;
    w.start_x = sx;
    w.start_y = sy;
    w.ctrl_a_x = ax;
    w.ctrl_a_y = ay;
    w.ctrl_b_x = bx;
    w.ctrl_b_y = by;
    w.finish_x = fx;
    w.finish_y = fy;
    w.split_t = t;
    return w;
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_curve(bzs_pkg::item_t w);
    @(negedge clk);
    start = 1'b1;
    item = w;
    do @(posedge clk); while (busy);
  endtask

  // Leaves start low for some cycles, with noise on the word.
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      item = rand_curve();
    end
  endtask

  initial begin
    int pct[4];
    pct[0] = 0;
    pct[1] = 63;
    pct[2] = 0;
    pct[3] = 7;
    rst = 1'b1;
    start = 1'b0;
    item = rand_curve();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: field extremes, both ends of t and a clamped t.
    send_curve(curve('0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                     bzs_pkg::T_ONE));
    send_curve(curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                     bzs_pkg::T_ONE >> 1));
    send_curve(curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, '0));
    send_curve(curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                     bzs_pkg::T_ONE));
    send_curve(curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, T_TOP));
    send_curve(curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                     bzs_pkg::T_ONE + bzs_pkg::t_t'(1)));
    send_curve(curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                     bzs_pkg::t_t'(1)));
    send_curve(curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                     bzs_pkg::T_ONE - bzs_pkg::t_t'(1)));
    send_curve(curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                     bzs_pkg::t_t'(17'h8000)));
    // Small negative steps, where flooring differs from truncation.
    send_curve(curve(cv(-1), cv(1), cv(0), cv(-1), cv(-1), cv(0), cv(0), cv(1),
                     bzs_pkg::t_t'(17'h5555)));
    send_curve(curve(cv(-1), cv(0), cv(0), cv(-1), cv(-1), cv(0), cv(0), cv(-1),
                     bzs_pkg::t_t'(1)));
    send_curve(curve(cv(3), cv(-3), cv(-5), cv(5), cv(7), cv(-7), cv(-2), cv(2),
                     bzs_pkg::t_t'(17'hAAAB)));
    send_curve(curve(cv(1), cv(2), cv(3), cv(4), cv(5), cv(6), cv(7), cv(8),
                     bzs_pkg::T_ONE + bzs_pkg::t_t'(17'h7FFF)));
    for (int i = 0; i < 4; i++) begin
      bzs_pkg::item_t w;
      w = rand_curve();
      w.split_t = (i == 0) ? bzs_pkg::t_t'('0) :
                  (i == 1) ? bzs_pkg::T_ONE : T_TOP - bzs_pkg::t_t'(i);
      send_curve(w);
    end

    // Random words in four phases; the sender idles only in the second and fourth.
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < RANDOM_WORDS / 4; i++) begin
        if ($urandom_range(1, 100) <= pct[ph]) hold_off($urandom_range(1, 12));
        send_curve(rand_curve());
      end
    end
    hold_off(1);

    // Drain, then allow a few more cycles for any stray point word.
    while (points.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (points.errors == 0) begin
      $display("cubic_bezier_subdivide verification clean");
    end else begin
      $display("cubic_bezier_subdivide verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/bzs_pkg.sv
src/bzs_cell.sv
src/cubic_bezier_subdivide.sv
verif/testbench.sv
